>>> design/cmfu_pkg.sv
// ----------------------------------------------------------------------------
// cmfu_pkg: shared definitions of the CAN motor feedback unwrap block
// Field widths, identifier constants, register indexes and the per-motor
// state entry kept in the state RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfu_pkg;

  localparam int ID_W     = 11;
  localparam int LEN_W    = 4;
  localparam int DECIM_W  = 9;
  localparam int CPR_W    = 16;
  localparam int ANGLE_W  = 16;
  localparam int TICK_W   = 64;
  localparam int MIDX_W   = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_MOTORS_DEF = 8;

  localparam logic [DECIM_W-1:0] DECIM_RESET = 9'd50;
  localparam logic [CPR_W-1:0]   CPR_RESET   = 16'd8192;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DECIM = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CPR   = 4'd1;

  localparam logic KIND_FEEDBACK = 1'b0;
  localparam logic KIND_FORWARD  = 1'b1;

  localparam logic [ID_W-1:0] MOTOR_ID_BASE  = 11'h200;
  localparam logic [ID_W-1:0] MOTOR_ID_FIRST = 11'h201;
  localparam logic [ID_W-1:0] MOTOR_ID_LAST  = 11'h208;
  localparam logic [ID_W-1:0] RSV_ID_LOW     = 11'h0FF;
  localparam logic [ID_W-1:0] RSV_RANGE_LO   = 11'h100;
  localparam logic [ID_W-1:0] RSV_RANGE_HI   = 11'h108;
  localparam logic [ID_W-1:0] RSV_ID_HIGH    = 11'h1FF;

  typedef struct packed {
    logic [ANGLE_W-1:0] last_angle;
    logic [TICK_W-1:0]  tick_sum;
    logic [DECIM_W-1:0] decim_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic is_reserved(input logic [ID_W-1:0] id);
    return (id == RSV_ID_LOW) || ((id >= RSV_RANGE_LO) && (id <= RSV_RANGE_HI)) ||
           (id == RSV_ID_HIGH) || (id == MOTOR_ID_BASE);
  endfunction

endpackage

`default_nettype wire

>>> design/cmfu_ram.sv
// ----------------------------------------------------------------------------
// cmfu_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered and a read
// of the entry being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfu_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/can_motor_feedback_unwrap.sv
// ----------------------------------------------------------------------------
// can_motor_feedback_unwrap: CAN motor feedback decoder with multiturn unwrap
// Unpacks motor feedback frames, accumulates unwrapped angle ticks per motor,
// decimates the feedback results and forwards other frames raw.
// ----------------------------------------------------------------------------
// The block takes one received frame per beat and sustains one frame per
// clock cycle while the output is not stalled. In the cycle a frame is accepted
// the motor's state entry is read from the state RAM; in stage 1 the angle step
// is unwrapped, the 64-bit tick sum and the decimation counter are updated, and
// when stage 1 advances they are written back and the result is loaded into the
// output register. A frame that follows a frame of the same motor takes the
// written-back entry from a forwarding register instead of the RAM. Per-motor
// valid flops stand for the first-frame flag, so no clearing pass is needed
// after reset. Configuration is written through a port that is always ready.
`default_nettype none

module can_motor_feedback_unwrap
  import cmfu_pkg::*;
#(
  parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,

  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [ID_W-1:0]       can_id_i,
  input  wire logic [LEN_W-1:0]      frame_len_i,
  input  wire logic [7:0]            byte0_i,
  input  wire logic [7:0]            byte1_i,
  input  wire logic [7:0]            byte2_i,
  input  wire logic [7:0]            byte3_i,
  input  wire logic [7:0]            byte4_i,
  input  wire logic [7:0]            byte5_i,
  input  wire logic [7:0]            byte6_i,
  input  wire logic [7:0]            byte7_i,

  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       kind_o,
  output logic        [MIDX_W-1:0]   motor_index_o,
  output logic        [ANGLE_W-1:0]  rotor_angle_o,
  output logic signed [15:0]         speed_o,
  output logic signed [15:0]         current_o,
  output logic        [7:0]          temperature_o,
  output logic signed [TICK_W-1:0]   total_ticks_o,
  output logic        [ID_W-1:0]     fwd_id_o,
  output logic        [LEN_W-1:0]    fwd_len_o,
  output logic        [63:0]         fwd_payload_o
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam logic [ID_W-1:0] MOTOR_ID_TOP = ID_W'(int'(MOTOR_ID_BASE) + NUM_MOTORS);

  // Configuration registers.
  logic [DECIM_W-1:0] decim_q;
  logic [CPR_W-1:0]   cpr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q <= DECIM_RESET;
      cpr_q   <= CPR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_IDX_DECIM) begin
        decim_q <= cfg_data_i[DECIM_W-1:0];
      end else if (cfg_index_i == CFG_IDX_CPR) begin
        cpr_q <= cfg_data_i[CPR_W-1:0];
      end
    end
  end

  // Stage 0: classify the frame and issue the state read.
  logic              in_accept;
  logic              in_motor;
  logic              in_fwd;
  logic [ID_W-1:0]   in_off;
  logic [IDX_W-1:0]  in_addr;
  logic [63:0]       in_payload;

  assign in_motor   = (can_id_i >= MOTOR_ID_FIRST) && (can_id_i <= MOTOR_ID_TOP);
  assign in_fwd     = !((can_id_i >= MOTOR_ID_FIRST) && (can_id_i <= MOTOR_ID_LAST)) &&
                      !is_reserved(can_id_i);
  assign in_off     = can_id_i - MOTOR_ID_FIRST;
  assign in_addr    = in_off[IDX_W-1:0];
  assign in_payload = {byte0_i, byte1_i, byte2_i, byte3_i,
                       byte4_i, byte5_i, byte6_i, byte7_i};

  // Stage 1 registers.
  logic             s1_valid_q;
  logic             s1_motor_q;
  logic             s1_fwd_q;
  logic [IDX_W-1:0] s1_addr_q;
  logic [ID_W-1:0]  s1_id_q;
  logic [LEN_W-1:0] s1_len_q;
  logic [63:0]      s1_payload_q;

  logic out_valid_q;
  logic s1_adv;
  logic wr_en;

  // Stage 1 moves on whenever the output register is empty or drains now.
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign wr_en      = s1_valid_q && s1_adv && s1_motor_q;

  // State RAM, valid flops and forwarding register.
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [NUM_MOTORS-1:0] valid_q;
  logic                  byp_vld_q;
  entry_t                byp_entry_q;
  entry_t                wr_entry;

  cmfu_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (NUM_MOTORS),
    .ADDR_W (IDX_W)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_entry),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_vld_q  <= 1'b0;
      valid_q    <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        // The entry written at this edge is missed by the RAM read.
        byp_vld_q  <= wr_en && (s1_addr_q == in_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_motor_q   <= in_motor;
      s1_fwd_q     <= in_fwd;
      s1_addr_q    <= in_addr;
      s1_id_q      <= can_id_i;
      s1_len_q     <= frame_len_i;
      s1_payload_q <= in_payload;
      byp_entry_q  <= wr_entry;
    end
  end

  // Stage 1: unwrap, accumulate and decimate.
  entry_t              rd_entry;
  entry_t              cur_entry;
  logic                first;
  logic [ANGLE_W-1:0]  angle;
  logic signed [17:0]  half_s;
  logic signed [17:0]  cpr_s;
  logic signed [17:0]  delta_raw;
  logic signed [17:0]  delta;
  logic [TICK_W-1:0]   tick_new;
  logic [DECIM_W-1:0]  cnt_inc;
  logic [DECIM_W-1:0]  period;
  logic                emit;

  assign rd_entry  = byp_vld_q ? byp_entry_q : entry_t'(ram_rdata);
  assign first     = !valid_q[s1_addr_q];
  assign cur_entry = first ? entry_t'('0) : rd_entry;
  assign angle     = s1_payload_q[63:48];
  assign half_s    = $signed({3'b000, cpr_q[CPR_W-1:1]});
  assign cpr_s     = $signed({2'b00, cpr_q});
  assign delta_raw = $signed({2'b00, angle}) - $signed({2'b00, cur_entry.last_angle});

  always_comb begin
    priority if (delta_raw > half_s) begin
      delta = delta_raw - cpr_s;
    end else if (delta_raw < -half_s) begin
      delta = delta_raw + cpr_s;
    end else begin
      delta = delta_raw;
    end
  end

  assign tick_new = first ? cur_entry.tick_sum
                          : cur_entry.tick_sum + {{(TICK_W-18){delta[17]}}, delta};
  assign cnt_inc  = cur_entry.decim_count + 9'd1;
  assign period   = (decim_q == '0) ? 9'd1 : decim_q;
  assign emit     = cnt_inc >= period;

  always_comb begin
    wr_entry.last_angle  = angle;
    wr_entry.tick_sum    = tick_new;
    wr_entry.decim_count = emit ? '0 : cnt_inc;
  end

  // Output register.
  logic               kind_q;
  logic [MIDX_W-1:0]  motor_index_q;
  logic [ANGLE_W-1:0] rotor_angle_q;
  logic [15:0]        speed_q;
  logic [15:0]        current_q;
  logic [7:0]         temperature_q;
  logic [TICK_W-1:0]  total_ticks_q;
  logic [ID_W-1:0]    fwd_id_q;
  logic [LEN_W-1:0]   fwd_len_q;
  logic [63:0]        fwd_payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q && ((s1_motor_q && emit) || s1_fwd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_motor_q) begin
        kind_q        <= KIND_FEEDBACK;
        motor_index_q <= MIDX_W'(s1_addr_q) + 4'd1;
        rotor_angle_q <= angle;
        speed_q       <= s1_payload_q[47:32];
        current_q     <= s1_payload_q[31:16];
        temperature_q <= s1_payload_q[15:8];
        total_ticks_q <= tick_new;
        fwd_id_q      <= '0;
        fwd_len_q     <= '0;
        fwd_payload_q <= '0;
      end else begin
        kind_q        <= KIND_FORWARD;
        motor_index_q <= '0;
        rotor_angle_q <= '0;
        speed_q       <= '0;
        current_q     <= '0;
        temperature_q <= '0;
        total_ticks_q <= '0;
        fwd_id_q      <= s1_id_q;
        fwd_len_q     <= s1_len_q;
        fwd_payload_q <= s1_payload_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign motor_index_o = motor_index_q;
  assign rotor_angle_o = rotor_angle_q;
  assign speed_o       = $signed(speed_q);
  assign current_o     = $signed(current_q);
  assign temperature_o = temperature_q;
  assign total_ticks_o = $signed(total_ticks_q);
  assign fwd_id_o      = fwd_id_q;
  assign fwd_len_o     = fwd_len_q;
  assign fwd_payload_o = fwd_payload_q;

  // Assertions.
  a_byp_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && byp_vld_q) |-> valid_q[s1_addr_q])
    else $error("forwarded entry for a motor without a valid state entry");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(s1_addr_q)])
    else $error("state write did not mark the motor entry valid");

  a_count_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_entry.decim_count < period))
    else $error("decimation count written back at or above the period");

  a_fwd_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == KIND_FORWARD)) |-> (total_ticks_q == '0 && motor_index_q == '0))
    else $error("forwarded beat carries motor feedback fields");

endmodule

`default_nettype wire

>>> tb/can_motor_feedback_unwrap_test.sv
// ----------------------------------------------------------------------------
// can_motor_feedback_unwrap_test: self-checking bench for the CAN motor decoder
// Sends CAN frames under several register settings. A predictor keeps its own
// per-motor angle, tick sum and decimation state. Every result beat is checked
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module can_motor_feedback_unwrap_test;
  import cmfu_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int PIPE_LATENCY = 2;
  localparam int MAX_PRINTS   = 40;
  localparam int NMOT         = NUM_MOTORS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'hF;

  typedef struct {
    logic               kind;
    logic [MIDX_W-1:0]  motor;
    logic [ANGLE_W-1:0] angle;
    logic [15:0]        speed;
    logic [15:0]        current;
    logic [7:0]         temp;
    logic [TICK_W-1:0]  ticks;
    logic [ID_W-1:0]    fwd_id;
    logic [LEN_W-1:0]   fwd_len;
    logic [63:0]        payload;
  } decoded_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [ID_W-1:0]   can_id     = '0;
  logic [LEN_W-1:0]  frame_len  = '0;
  logic [63:0]       frame_data = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     kind;
  logic        [MIDX_W-1:0] motor_index;
  logic       [ANGLE_W-1:0] rotor_angle;
  logic signed [15:0]       speed;
  logic signed [15:0]       current;
  logic        [7:0]        temperature;
  logic signed [TICK_W-1:0] total_ticks;
  logic        [ID_W-1:0]   fwd_id;
  logic        [LEN_W-1:0]  fwd_len;
  logic        [63:0]       fwd_payload;

  // Predictor copy of the registers and the per-motor state.
  logic [DECIM_W-1:0] decim_period;
  logic [CPR_W-1:0]   cpr;
  logic [ANGLE_W-1:0] prev_angle   [NMOT];
  bit                 first_pending[NMOT];
  logic [TICK_W-1:0]  tick_total   [NMOT];
  logic [DECIM_W-1:0] frame_count  [NMOT];

  decoded_t decoded_q[$];

  int errors = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int settings_used = 0;

  // Stimulus side: angle walk per motor and sender burst control.
  logic [ANGLE_W-1:0] gen_angle[NMOT];
  int last_motor = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  can_motor_feedback_unwrap DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .can_id_i      (can_id),
    .frame_len_i   (frame_len),
    .byte0_i       (frame_data[63:56]),
    .byte1_i       (frame_data[55:48]),
    .byte2_i       (frame_data[47:40]),
    .byte3_i       (frame_data[39:32]),
    .byte4_i       (frame_data[31:24]),
    .byte5_i       (frame_data[23:16]),
    .byte6_i       (frame_data[15:8]),
    .byte7_i       (frame_data[7:0]),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .kind_o        (kind),
    .motor_index_o (motor_index),
    .rotor_angle_o (rotor_angle),
    .speed_o       (speed),
    .current_o     (current),
    .temperature_o (temperature),
    .total_ticks_o (total_ticks),
    .fwd_id_o      (fwd_id),
    .fwd_len_o     (fwd_len),
    .fwd_payload_o (fwd_payload)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit dropped_id(input logic [ID_W-1:0] id);
    return (id == RSV_ID_LOW) || (id >= RSV_RANGE_LO && id <= RSV_RANGE_HI) ||
           (id == RSV_ID_HIGH) || (id == MOTOR_ID_BASE);
  endfunction

  // Unpacks one frame, unwraps the angle step and queues the result, if any.
  task automatic decode_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                              input logic [63:0] data);
    decoded_t r;
    int m;
    int half;
    int delta;
    longint step;
    logic [ANGLE_W-1:0] angle;
    logic [DECIM_W-1:0] period;
    r = '{default: '0};
    if (id >= MOTOR_ID_FIRST && id <= MOTOR_ID_LAST) begin
      m = int'(id - MOTOR_ID_FIRST);
      if (m >= NMOT) return;
      angle = data[63:48];
      if (first_pending[m]) begin
        first_pending[m] = 1'b0;
      end else begin
        half  = int'(cpr) / 2;
        delta = int'(angle) - int'(prev_angle[m]);
        if (delta > half) delta -= int'(cpr);
        else if (delta < -half) delta += int'(cpr);
        step = delta;
        tick_total[m] = tick_total[m] + step;
      end
      prev_angle[m] = angle;
      period = (decim_period == '0) ? 9'd1 : decim_period;
      frame_count[m] = frame_count[m] + 1'b1;
      if (frame_count[m] < period) return;
      frame_count[m] = '0;
      r.kind    = KIND_FEEDBACK;
      r.motor   = MIDX_W'(m + 1);
      r.angle   = angle;
      r.speed   = data[47:32];
      r.current = data[31:16];
      r.temp    = data[15:8];
      r.ticks   = tick_total[m];
    end else if (dropped_id(id)) begin
      return;
    end else begin
      r.kind    = KIND_FORWARD;
      r.fwd_id  = id;
      r.fwd_len = len;
      r.payload = data;
    end
    decoded_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH %s: got %h, expected %h (t=%0t)", what, got, want, $time);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Sends one frame and returns at the edge that accepts its beat.
  task automatic send_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                            input logic [63:0] data);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid   <= 1'b1;
    can_id     <= id;
    frame_len  <= len;
    frame_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_frame(id, len, data);
    frames_sent++;
  endtask

  // The length code is ignored on motor frames, so it is left random there.
  task automatic motor_frame(input int m, input logic [15:0] angle, input logic [15:0] spd,
                             input logic [15:0] cur, input logic [7:0] temp);
    send_frame(MOTOR_ID_FIRST + ID_W'(m), LEN_W'($urandom),
               {angle, spd, cur, temp, 8'($urandom)});
  endtask

  // Drains all outstanding results, then lets frames that give none finish too.
  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDX_DECIM) decim_period = value[DECIM_W-1:0];
    else if (idx == CFG_IDX_CPR) cpr = value;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] period, input logic [CFG_DATA_W-1:0] rev);
    write_reg(CFG_IDX_DECIM, period);
    write_reg(CFG_IDX_CPR, rev);
    settings_used++;
  endtask

  // Mostly plausible encoder walks per motor, with steps around the half
  // revolution, plus raw frames, dropped identifiers and identifiers near edges.
  task automatic random_item();
    int pick;
    int m;
    int span;
    int half;
    int step;
    logic [ANGLE_W-1:0] angle;
    logic [ID_W-1:0] id;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      m = ($urandom_range(0, 9) < 4) ? last_motor : int'($urandom_range(0, NMOT - 1));
      last_motor = m;
      span = (cpr == '0) ? 65536 : int'(cpr);
      half = span / 2;
      step = 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        step = int'($urandom_range(0, 128)) - 64;
      end else if (pick < 85) begin
        step = int'($urandom_range(0, span)) - half;
      end else if (pick < 93) begin
        case ($urandom_range(0, 3))
          0: step = half;
          1: step = half + 1;
          2: step = -half;
          default: step = -half - 1;
        endcase
      end
      if (pick < 93) angle = ANGLE_W'(((int'(gen_angle[m]) + step) % span + span) % span);
      else angle = ANGLE_W'($urandom);
      gen_angle[m] = angle;
      motor_frame(m, angle, 16'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      if (pick < 82) begin
        id = ID_W'($urandom);
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0: id = RSV_ID_LOW;
          1: id = RSV_RANGE_LO + ID_W'($urandom_range(0, 8));
          2: id = RSV_ID_HIGH;
          default: id = MOTOR_ID_BASE;
        endcase
      end else begin
        id = ID_W'($urandom_range(int'(RSV_ID_LOW) - 15, int'(MOTOR_ID_LAST) + 23));
      end
      send_frame(id, LEN_W'($urandom), {$urandom, $urandom});
    end
  endtask

  // Registers at their reset values: one result after fifty frames of a motor.
  task automatic test_reset_defaults();
    logic [15:0] a;
    a = 16'h0100;
    for (int i = 0; i < 50; i++) begin
      motor_frame(2, a, 16'($urandom), 16'($urandom), 8'($urandom));
      a = a + 16'd150;
    end
    gen_angle[2] = a - 16'd150;
    for (int i = 0; i < 4; i++)
      send_frame(ID_W'($urandom_range(0, 250)), 4'd8, {$urandom, $urandom});
    settings_used++;
  endtask

  task automatic test_directed();
    configure(16'd1, 16'd8192);
    // Motor 1: first frame, then steps of exactly half a revolution and one past.
    motor_frame(0, 16'h1000, 16'h7FFF, 16'h8000, 8'h00);
    motor_frame(0, 16'h2000, 16'h8000, 16'h7FFF, 8'hFF);
    motor_frame(0, 16'h3001, 16'h0000, 16'hFFFF, 8'h55);
    motor_frame(0, 16'h2001, 16'hFFFF, 16'h0000, 8'hAA);
    motor_frame(0, 16'h1000, 16'h1234, 16'h8765, 8'h01);
    motor_frame(0, 16'hFFFF, 16'h8001, 16'h7FFE, 8'hFE);
    motor_frame(0, 16'h0000, 16'h0001, 16'h0001, 8'h80);
    motor_frame(NMOT - 1, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF);
    motor_frame(NMOT - 1, 16'h0000, 16'h7FFF, 16'h8000, 8'h00);
    gen_angle[0] = '0;
    gen_angle[NMOT - 1] = '0;
    send_frame(RSV_ID_LOW, 4'd8, {$urandom, $urandom});
    send_frame(RSV_RANGE_LO, 4'd8, {$urandom, $urandom});
    send_frame(RSV_RANGE_HI, 4'd8, {$urandom, $urandom});
    send_frame(RSV_ID_HIGH, 4'd8, {$urandom, $urandom});
    send_frame(MOTOR_ID_BASE, 4'd8, {$urandom, $urandom});
    send_frame('0, '0, '0);
    send_frame('1, '1, '1);
    send_frame(MOTOR_ID_LAST + 1'b1, 4'd8, {$urandom, $urandom});
    send_frame(RSV_ID_LOW - 1'b1, 4'd3, {$urandom, $urandom});
    send_frame(RSV_RANGE_HI + 1'b1, 4'd1, {$urandom, $urandom});
    send_frame(RSV_ID_HIGH - 1'b1, 4'd9, {$urandom, $urandom});
  endtask

  task automatic test_config_corners();
    logic [CFG_DATA_W-1:0] periods[7] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd511, 16'd500,
                                          16'd1};
    logic [CFG_DATA_W-1:0] revs[7]    = '{16'd8192, 16'd0, 16'd2, 16'd32768, 16'd4097,
                                          16'd65535, 16'd2};
    for (int s = 0; s < 7; s++) begin
      configure(periods[s], revs[s]);
      repeat (40) random_item();
    end
    // Upper data bits beyond the period width are dropped; a spare index is ignored.
    write_reg(CFG_IDX_DECIM, 16'hFE03);
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    settings_used++;
    repeat (40) random_item();
  endtask

  task automatic test_random();
    int p;
    logic [CFG_DATA_W-1:0] period;
    logic [CFG_DATA_W-1:0] rev;
    for (int phase = 0; phase < 7; phase++) begin
      p = $urandom_range(0, 9);
      if (p < 5) period = CFG_DATA_W'($urandom_range(1, 4));
      else if (p < 8) period = CFG_DATA_W'($urandom_range(5, 25));
      else if (p == 8) period = '0;
      else period = CFG_DATA_W'($urandom_range(100, 500));
      case ($urandom_range(0, 7))
        0: rev = 16'd2;
        1: rev = 16'd32768;
        2: rev = 16'd8192;
        3: rev = 16'd4096;
        4: rev = '0;
        5: rev = 16'($urandom);
        default: rev = CFG_DATA_W'($urandom_range(2, 32768));
      endcase
      configure(period, rev);
      gaps_on = (phase != 3);
      repeat (150) random_item();
    end
    gaps_on = 1'b1;
  endtask

  // Receiver back-pressure changes its character whenever a random mode counter runs out.
  stall_mode_e stall_mode = STALL_NONE;
  int mode_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_COIN: out_stall <= 1'($urandom);
      STALL_PERIODIC: out_stall <= (mode_left % 4 == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", {63'd0, kind}, '0);
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", kind, want.kind);
        check_field("motor_index", motor_index, want.motor);
        check_field("rotor_angle", rotor_angle, want.angle);
        check_field("speed", $unsigned(speed), want.speed);
        check_field("current", $unsigned(current), want.current);
        check_field("temperature", temperature, want.temp);
        check_field("total_ticks", $unsigned(total_ticks), want.ticks);
        check_field("fwd_id", fwd_id, want.fwd_id);
        check_field("fwd_len", fwd_len, want.fwd_len);
        check_field("fwd_payload", fwd_payload, want.payload);
        results_checked++;
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main
    decim_period = DECIM_RESET;
    cpr = CPR_RESET;
    for (int i = 0; i < NMOT; i++) begin
      prev_angle[i]    = '0;
      first_pending[i] = 1'b1;
      tick_total[i]    = '0;
      frame_count[i]   = '0;
      gen_angle[i]     = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_config_corners();
    test_random();
    settle();
    $display("Covered %0d frames under %0d register settings, %0d results compared.",
             frames_sent, settings_used, results_checked);
    $display("Field mismatches seen: %0d", errors);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
